### hdl/rmtp_pkg.sv
`timescale 1ns / 1ps

package rmtp_pkg;

    localparam int COORD_W              = 32;
    localparam int TEX_W                = 16;
    localparam int COORD_FRAC_BITS_DEF  = 16;
    localparam int CFG_IDX_W            = 3;
    localparam int ACC_W                = 128;
    localparam int MPL_W                = 34;
    localparam int MPL_CNT_W            = $clog2(MPL_W);
    localparam int DEN_W                = 104;
    localparam int QUO_W                = COORD_W - 1;
    localparam int QCNT_W               = $clog2(QUO_W + 1);
    localparam int STEP_W               = 5;
    localparam int EPS_SCALE            = 10000;
    localparam logic [STEP_W-1:0] GEO_LAST = STEP_W'(23);
    localparam logic [STEP_W-1:0] TEX_LAST = STEP_W'(29);
    localparam logic [COORD_W-1:0] DIST_SAT = {1'b1, {(COORD_W-1){1'b0}}};

    typedef struct packed {
        logic signed [COORD_W-1:0] pos_x;
        logic signed [COORD_W-1:0] pos_y;
        logic signed [COORD_W-1:0] pos_z;
        logic [TEX_W-1:0]          tex_u;
        logic [TEX_W-1:0]          tex_v;
        logic                      last_in_mesh;
    } vertex_t;

    typedef struct packed {
        logic                      hit;
        logic [TEX_W-1:0]          hit_u;
        logic [TEX_W-1:0]          hit_v;
        logic signed [COORD_W-1:0] hit_distance;
    } pick_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ORIGIN_X = 3'd0,
        REG_ORIGIN_Y = 3'd1,
        REG_ORIGIN_Z = 3'd2,
        REG_DIR_X    = 3'd3,
        REG_DIR_Y    = 3'd4,
        REG_DIR_Z    = 3'd5
    } cfg_reg_t;

    typedef enum logic [4:0] {
        N_DX, N_DY, N_DZ, N_SX, N_SY, N_SZ, N_E1X, N_E1Y, N_E1Z,
        N_E2X, N_E2Y, N_E2Z, N_U0, N_DU1, N_DU2, N_V0, N_DV1, N_DV2
    } narrow_sel_t;

    typedef enum logic [3:0] {
        W_E1X, W_E1Y, W_E1Z, W_E2X, W_E2Y, W_E2Z, W_PX, W_PY, W_PZ,
        W_QX, W_QY, W_QZ, W_DET, W_UN, W_VN
    } wide_sel_t;

    typedef enum logic [3:0] {
        D_NONE, D_PX, D_PY, D_PZ, D_QX, D_QY, D_QZ, D_DET, D_UN, D_VN, D_TN,
        D_NUMU, D_NUMV
    } dst_t;

    typedef enum logic [1:0] {
        DV_U, DV_V, DV_T
    } div_sel_t;

    typedef enum logic [3:0] {
        S_IDLE, S_MAC, S_MAC_WAIT, S_NORM, S_CHK_A, S_CHK_B, S_DIV, S_DIV_WAIT,
        S_SAT, S_FINISH
    } state_t;

    typedef struct packed {
        narrow_sel_t nsel;
        wide_sel_t   wsel;
        logic        first;
        logic        neg;
        dst_t        dst;
    } uop_t;

    typedef struct packed {
        logic start;
        logic clear;
        logic neg;
    } mac_cmd_t;

    typedef struct packed {
        logic              start;
        logic [QCNT_W-1:0] count;
    } div_cmd_t;

    typedef struct packed {
        logic busy;
        logic done;
    } unit_stat_t;

    function automatic uop_t mk(input narrow_sel_t n, input wide_sel_t w, input logic f,
                                input logic g, input dst_t d);
        uop_t u;
        u.nsel  = n;
        u.wsel  = w;
        u.first = f;
        u.neg   = g;
        u.dst   = d;
        return u;
    endfunction

    // Each entry is acc (+/-)= narrow * wide; the destination is written when the entry ends.
    function automatic uop_t uop_rom(input logic [STEP_W-1:0] idx);
        uop_t u;
        unique case (idx)
            5'd0:    u = mk(N_DY,  W_E2Z, 1'b1, 1'b0, D_NONE);
            5'd1:    u = mk(N_DZ,  W_E2Y, 1'b0, 1'b1, D_PX);
            5'd2:    u = mk(N_DZ,  W_E2X, 1'b1, 1'b0, D_NONE);
            5'd3:    u = mk(N_DX,  W_E2Z, 1'b0, 1'b1, D_PY);
            5'd4:    u = mk(N_DX,  W_E2Y, 1'b1, 1'b0, D_NONE);
            5'd5:    u = mk(N_DY,  W_E2X, 1'b0, 1'b1, D_PZ);
            5'd6:    u = mk(N_E1X, W_PX,  1'b1, 1'b0, D_NONE);
            5'd7:    u = mk(N_E1Y, W_PY,  1'b0, 1'b0, D_NONE);
            5'd8:    u = mk(N_E1Z, W_PZ,  1'b0, 1'b0, D_DET);
            5'd9:    u = mk(N_SX,  W_PX,  1'b1, 1'b0, D_NONE);
            5'd10:   u = mk(N_SY,  W_PY,  1'b0, 1'b0, D_NONE);
            5'd11:   u = mk(N_SZ,  W_PZ,  1'b0, 1'b0, D_UN);
            5'd12:   u = mk(N_SY,  W_E1Z, 1'b1, 1'b0, D_NONE);
            5'd13:   u = mk(N_SZ,  W_E1Y, 1'b0, 1'b1, D_QX);
            5'd14:   u = mk(N_SZ,  W_E1X, 1'b1, 1'b0, D_NONE);
            5'd15:   u = mk(N_SX,  W_E1Z, 1'b0, 1'b1, D_QY);
            5'd16:   u = mk(N_SX,  W_E1Y, 1'b1, 1'b0, D_NONE);
            5'd17:   u = mk(N_SY,  W_E1X, 1'b0, 1'b1, D_QZ);
            5'd18:   u = mk(N_DX,  W_QX,  1'b1, 1'b0, D_NONE);
            5'd19:   u = mk(N_DY,  W_QY,  1'b0, 1'b0, D_NONE);
            5'd20:   u = mk(N_DZ,  W_QZ,  1'b0, 1'b0, D_VN);
            5'd21:   u = mk(N_E2X, W_QX,  1'b1, 1'b0, D_NONE);
            5'd22:   u = mk(N_E2Y, W_QY,  1'b0, 1'b0, D_NONE);
            5'd23:   u = mk(N_E2Z, W_QZ,  1'b0, 1'b0, D_TN);
            5'd24:   u = mk(N_U0,  W_DET, 1'b1, 1'b0, D_NONE);
            5'd25:   u = mk(N_DU1, W_UN,  1'b0, 1'b0, D_NONE);
            5'd26:   u = mk(N_DU2, W_VN,  1'b0, 1'b0, D_NUMU);
            5'd27:   u = mk(N_V0,  W_DET, 1'b1, 1'b0, D_NONE);
            5'd28:   u = mk(N_DV1, W_UN,  1'b0, 1'b0, D_NONE);
            5'd29:   u = mk(N_DV2, W_VN,  1'b0, 1'b0, D_NUMV);
            default: u = mk(N_DX,  W_E1X, 1'b1, 1'b0, D_NONE);
        endcase
        return u;
    endfunction

endpackage

### hdl/rmtp_mac.sv
`timescale 1ns / 1ps

module rmtp_mac (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  rmtp_pkg::mac_cmd_t           cmd,
    input  logic [rmtp_pkg::MPL_W-1:0]   narrow,
    input  logic [rmtp_pkg::ACC_W-1:0]   wide,
    output rmtp_pkg::unit_stat_t         stat,
    output logic [rmtp_pkg::ACC_W-1:0]   acc
);
    import rmtp_pkg::*;

    logic [ACC_W-1:0]     acc_reg;
    logic [ACC_W-1:0]     mcand_reg;
    logic [MPL_W-1:0]     mpl_reg;
    logic [MPL_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic                 neg_reg;
    logic                 last_bit;
    logic                 sub_now;
    logic [ACC_W-1:0]     addend;
    logic [ACC_W-1:0]     acc_next;

    // The top multiplier bit carries negative weight.
    always_comb begin
        last_bit = (cnt_reg == MPL_CNT_W'(MPL_W - 1));
        sub_now  = neg_reg ^ last_bit;
        addend   = mpl_reg[0] ? mcand_reg : '0;
        acc_next = sub_now ? acc_reg - addend : acc_reg + addend;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (cmd.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + MPL_CNT_W'(1);
                if (last_bit) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            acc_reg   <= cmd.clear ? '0 : acc_reg;
            mcand_reg <= wide;
            mpl_reg   <= narrow;
            neg_reg   <= cmd.neg;
        end else if (busy_reg) begin
            acc_reg   <= acc_next;
            mcand_reg <= {mcand_reg[ACC_W-2:0], 1'b0};
            mpl_reg   <= {1'b0, mpl_reg[MPL_W-1:1]};
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign acc       = acc_reg;

endmodule

### hdl/rmtp_div.sv
`timescale 1ns / 1ps

module rmtp_div (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  rmtp_pkg::div_cmd_t           cmd,
    input  logic [rmtp_pkg::DEN_W-1:0]   rem_init,
    input  logic [rmtp_pkg::QUO_W-1:0]   low_bits,
    input  logic [rmtp_pkg::DEN_W-1:0]   den,
    output rmtp_pkg::unit_stat_t         stat,
    output logic [rmtp_pkg::QUO_W-1:0]   quo
);
    import rmtp_pkg::*;

    logic [DEN_W-1:0]  rem_reg;
    logic [DEN_W-1:0]  den_reg;
    logic [QUO_W-1:0]  bits_reg;
    logic [QUO_W-1:0]  quo_reg;
    logic [QCNT_W-1:0] cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [DEN_W:0]    rem_shift;
    logic              fits;
    logic [DEN_W:0]    rem_sub;

    always_comb begin
        rem_shift = {rem_reg, bits_reg[QUO_W-1]};
        fits      = rem_shift >= {1'b0, den_reg};
        rem_sub   = rem_shift - {1'b0, den_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (cmd.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= cmd.count;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - QCNT_W'(1);
                if (cnt_reg == QCNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            rem_reg  <= rem_init;
            den_reg  <= den;
            bits_reg <= low_bits;
            quo_reg  <= '0;
        end else if (busy_reg) begin
            rem_reg  <= fits ? rem_sub[DEN_W-1:0] : rem_shift[DEN_W-1:0];
            bits_reg <= {bits_reg[QUO_W-2:0], 1'b0};
            quo_reg  <= {quo_reg[QUO_W-2:0], fits};
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quo       = quo_reg;

endmodule

### hdl/ray_mesh_triangle_pick.sv
// Picks a triangle mesh with one ray set through the configuration port. Vertices arrive one per
// transaction and every third vertex closes a triangle, which gets an exact fixed-point
// Moller-Trumbore test; a hit records the interpolated texture coordinate and the distance, and a
// later hit replaces an earlier one. The vertex flagged last_in_mesh produces one result and
// clears the mesh. A closing vertex runs 24 serial multiply-accumulate steps on one shared
// shift-add unit; a hit then takes 6 more multiply-accumulates and up to three restoring
// divisions, of 16 quotient bits for the texture coordinates and 31 for the distance. The input
// is not ready during that time.
`timescale 1ns / 1ps

module ray_mesh_triangle_pick #(
    parameter int COORD_FRAC_BITS = rmtp_pkg::COORD_FRAC_BITS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  rmtp_pkg::vertex_t               s_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output rmtp_pkg::pick_t                 m_data,
    input  logic                            cfg_wr_en,
    input  logic [rmtp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rmtp_pkg::COORD_W-1:0]    cfg_wdata
);
    import rmtp_pkg::*;

    localparam int SAT_SH = (COORD_W - 1) - COORD_FRAC_BITS;
    localparam logic [ACC_W-1:0] EPS_POW = ACC_W'(1) << (3 * COORD_FRAC_BITS);
    localparam logic [ACC_W-1:0] EPS_LIM = (EPS_POW + ACC_W'(EPS_SCALE - 1)) / ACC_W'(EPS_SCALE);

    state_t state_reg, state_next;

    logic signed [COORD_W-1:0] org_reg [3];
    logic signed [COORD_W-1:0] dir_reg [3];
    logic signed [COORD_W-1:0] v0_reg  [3];
    logic signed [COORD_W-1:0] v1_reg  [3];
    logic [TEX_W-1:0]          tu_reg  [3];
    logic [TEX_W-1:0]          tv_reg  [3];
    logic signed [COORD_W:0]   e1_reg  [3];
    logic signed [COORD_W:0]   e2_reg  [3];
    logic signed [COORD_W:0]   s_reg   [3];
    logic [ACC_W-1:0]          p_reg   [3];
    logic [ACC_W-1:0]          q_reg   [3];
    logic [ACC_W-1:0]          det_reg, un_reg, vn_reg, tn_reg, numu_reg, numv_reg;

    logic [1:0]        slot_reg;
    logic              last_reg;
    logic [STEP_W-1:0] step_reg;
    logic [1:0]        norm_cnt_reg;
    div_sel_t          div_sel_reg;
    logic              any_hit_reg;
    logic [TEX_W-1:0]  best_u_reg, best_v_reg;
    logic [COORD_W-1:0] best_dist_reg;
    logic              m_valid_reg;
    pick_t             m_data_reg;

    logic signed [COORD_W-1:0] in_pos [3];
    logic                      accept;
    logic                      out_load;
    uop_t                      uop;
    mac_cmd_t                  mac_cmd;
    unit_stat_t                mac_stat;
    logic [MPL_W-1:0]          mac_narrow;
    logic [ACC_W-1:0]          mac_wide;
    logic [ACC_W-1:0]          mac_acc;
    div_cmd_t                  div_cmd;
    unit_stat_t                div_stat;
    logic [DEN_W-1:0]          div_rem;
    logic [QUO_W-1:0]          div_bits;
    logic [QUO_W-1:0]          div_quo;
    logic signed [TEX_W:0]     du1, du2, dv1, dv2;
    logic [ACC_W-1:0]          neg_in;
    logic [ACC_W-1:0]          neg_out;
    logic [ACC_W-1:0]          t_mag;
    logic [ACC_W-1:0]          t_num;
    logic [ACC_W-1:0]          uv_sum;
    logic                      fail_a;
    logic                      sum_gt;
    logic                      sat;

    assign in_pos[0] = s_data.pos_x;
    assign in_pos[1] = s_data.pos_y;
    assign in_pos[2] = s_data.pos_z;
    assign accept    = s_valid && s_ready;
    assign uop       = uop_rom(step_reg);

    always_comb begin
        du1    = $signed({1'b0, tu_reg[1]}) - $signed({1'b0, tu_reg[0]});
        du2    = $signed({1'b0, tu_reg[2]}) - $signed({1'b0, tu_reg[0]});
        dv1    = $signed({1'b0, tv_reg[1]}) - $signed({1'b0, tv_reg[0]});
        dv2    = $signed({1'b0, tv_reg[2]}) - $signed({1'b0, tv_reg[0]});
        t_mag  = ACC_W'(0) - tn_reg;
        t_num  = t_mag << COORD_FRAC_BITS;
        uv_sum = un_reg + vn_reg;
        fail_a = (det_reg < EPS_LIM) || un_reg[ACC_W-1] || (un_reg > det_reg)
                 || vn_reg[ACC_W-1] || (!tn_reg[ACC_W-1] && (tn_reg != '0));
        sum_gt = uv_sum > det_reg;
        sat    = t_mag >= (det_reg << SAT_SH);
    end

    always_comb begin
        unique case (uop.nsel)
            N_DX:    mac_narrow = MPL_W'(dir_reg[0]);
            N_DY:    mac_narrow = MPL_W'(dir_reg[1]);
            N_DZ:    mac_narrow = MPL_W'(dir_reg[2]);
            N_SX:    mac_narrow = MPL_W'(s_reg[0]);
            N_SY:    mac_narrow = MPL_W'(s_reg[1]);
            N_SZ:    mac_narrow = MPL_W'(s_reg[2]);
            N_E1X:   mac_narrow = MPL_W'(e1_reg[0]);
            N_E1Y:   mac_narrow = MPL_W'(e1_reg[1]);
            N_E1Z:   mac_narrow = MPL_W'(e1_reg[2]);
            N_E2X:   mac_narrow = MPL_W'(e2_reg[0]);
            N_E2Y:   mac_narrow = MPL_W'(e2_reg[1]);
            N_E2Z:   mac_narrow = MPL_W'(e2_reg[2]);
            N_U0:    mac_narrow = MPL_W'(tu_reg[0]);
            N_DU1:   mac_narrow = MPL_W'(du1);
            N_DU2:   mac_narrow = MPL_W'(du2);
            N_V0:    mac_narrow = MPL_W'(tv_reg[0]);
            N_DV1:   mac_narrow = MPL_W'(dv1);
            N_DV2:   mac_narrow = MPL_W'(dv2);
            default: mac_narrow = '0;
        endcase
        unique case (uop.wsel)
            W_E1X:   mac_wide = ACC_W'(e1_reg[0]);
            W_E1Y:   mac_wide = ACC_W'(e1_reg[1]);
            W_E1Z:   mac_wide = ACC_W'(e1_reg[2]);
            W_E2X:   mac_wide = ACC_W'(e2_reg[0]);
            W_E2Y:   mac_wide = ACC_W'(e2_reg[1]);
            W_E2Z:   mac_wide = ACC_W'(e2_reg[2]);
            W_PX:    mac_wide = p_reg[0];
            W_PY:    mac_wide = p_reg[1];
            W_PZ:    mac_wide = p_reg[2];
            W_QX:    mac_wide = q_reg[0];
            W_QY:    mac_wide = q_reg[1];
            W_QZ:    mac_wide = q_reg[2];
            W_DET:   mac_wide = det_reg;
            W_UN:    mac_wide = un_reg;
            W_VN:    mac_wide = vn_reg;
            default: mac_wide = '0;
        endcase
    end

    always_comb begin
        unique case (norm_cnt_reg)
            2'd0:    neg_in = un_reg;
            2'd1:    neg_in = vn_reg;
            2'd2:    neg_in = tn_reg;
            default: neg_in = det_reg;
        endcase
        neg_out = ACC_W'(0) - neg_in;
    end

    always_comb begin
        unique case (div_sel_reg)
            DV_U: begin
                div_rem  = DEN_W'(numu_reg >> TEX_W);
                div_bits = {numu_reg[TEX_W-1:0], (QUO_W - TEX_W)'(0)};
            end
            DV_V: begin
                div_rem  = DEN_W'(numv_reg >> TEX_W);
                div_bits = {numv_reg[TEX_W-1:0], (QUO_W - TEX_W)'(0)};
            end
            default: begin
                div_rem  = DEN_W'(t_mag >> SAT_SH);
                div_bits = t_num[QUO_W-1:0];
            end
        endcase
    end

    always_comb begin
        state_next    = state_reg;
        mac_cmd       = '0;
        div_cmd.start = 1'b0;
        div_cmd.count = (div_sel_reg == DV_T) ? QCNT_W'(QUO_W) : QCNT_W'(TEX_W);
        out_load      = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    state_next = slot_reg[1] ? S_MAC : S_FINISH;
                end
            end
            S_MAC: begin
                mac_cmd.start = 1'b1;
                mac_cmd.clear = uop.first;
                mac_cmd.neg   = uop.neg;
                state_next    = S_MAC_WAIT;
            end
            S_MAC_WAIT: begin
                if (mac_stat.done) begin
                    if (step_reg == GEO_LAST) begin
                        state_next = S_NORM;
                    end else if (step_reg == TEX_LAST) begin
                        state_next = S_DIV;
                    end else begin
                        state_next = S_MAC;
                    end
                end
            end
            S_NORM: begin
                if (norm_cnt_reg == 2'd3) begin
                    state_next = S_CHK_A;
                end
            end
            S_CHK_A: state_next = fail_a ? S_FINISH : S_CHK_B;
            S_CHK_B: state_next = sum_gt ? S_FINISH : S_MAC;
            S_DIV: begin
                div_cmd.start = 1'b1;
                state_next    = S_DIV_WAIT;
            end
            S_DIV_WAIT: begin
                if (div_stat.done) begin
                    unique case (div_sel_reg)
                        DV_U:    state_next = S_DIV;
                        DV_V:    state_next = S_SAT;
                        default: state_next = S_FINISH;
                    endcase
                end
            end
            S_SAT: state_next = sat ? S_FINISH : S_DIV;
            S_FINISH: begin
                if (!last_reg) begin
                    state_next = S_IDLE;
                end else if (!m_valid_reg || m_ready) begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 3; i++) begin
                org_reg[i] <= '0;
                dir_reg[i] <= '0;
            end
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_ORIGIN_X: org_reg[0] <= cfg_wdata;
                REG_ORIGIN_Y: org_reg[1] <= cfg_wdata;
                REG_ORIGIN_Z: org_reg[2] <= cfg_wdata;
                REG_DIR_X:    dir_reg[0] <= cfg_wdata;
                REG_DIR_Y:    dir_reg[1] <= cfg_wdata;
                REG_DIR_Z:    dir_reg[2] <= cfg_wdata;
                default:      ;
            endcase
        end
    end

    // Vertex capture, the edge vectors of a closing triangle, the MAC results, their sign normalization and the result.
    always_ff @(posedge aclk) begin
        if (accept) begin
            unique case (slot_reg)
                2'd0: begin
                    v0_reg    <= in_pos;
                    tu_reg[0] <= s_data.tex_u;
                    tv_reg[0] <= s_data.tex_v;
                end
                2'd1: begin
                    v1_reg    <= in_pos;
                    tu_reg[1] <= s_data.tex_u;
                    tv_reg[1] <= s_data.tex_v;
                end
                default: begin
                    tu_reg[2] <= s_data.tex_u;
                    tv_reg[2] <= s_data.tex_v;
                    for (int i = 0; i < 3; i++) begin
                        e1_reg[i] <= (COORD_W + 1)'(v1_reg[i]) - (COORD_W + 1)'(v0_reg[i]);
                        e2_reg[i] <= (COORD_W + 1)'(in_pos[i]) - (COORD_W + 1)'(v0_reg[i]);
                        s_reg[i]  <= (COORD_W + 1)'(org_reg[i]) - (COORD_W + 1)'(v0_reg[i]);
                    end
                end
            endcase
        end
        if (state_reg == S_MAC_WAIT && mac_stat.done) begin
            unique case (uop.dst)
                D_PX:    p_reg[0] <= mac_acc;
                D_PY:    p_reg[1] <= mac_acc;
                D_PZ:    p_reg[2] <= mac_acc;
                D_QX:    q_reg[0] <= mac_acc;
                D_QY:    q_reg[1] <= mac_acc;
                D_QZ:    q_reg[2] <= mac_acc;
                D_DET:   det_reg  <= mac_acc;
                D_UN:    un_reg   <= mac_acc;
                D_VN:    vn_reg   <= mac_acc;
                D_TN:    tn_reg   <= mac_acc;
                D_NUMU:  numu_reg <= mac_acc;
                D_NUMV:  numv_reg <= mac_acc;
                default: ;
            endcase
        end
        if (state_reg == S_NORM && det_reg[ACC_W-1]) begin
            unique case (norm_cnt_reg)
                2'd0:    un_reg  <= neg_out;
                2'd1:    vn_reg  <= neg_out;
                2'd2:    tn_reg  <= neg_out;
                default: det_reg <= neg_out;
            endcase
        end
        if (out_load) begin
            m_data_reg.hit          <= any_hit_reg;
            m_data_reg.hit_u        <= best_u_reg;
            m_data_reg.hit_v        <= best_v_reg;
            m_data_reg.hit_distance <= best_dist_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_reg      <= '0;
            last_reg      <= 1'b0;
            step_reg      <= '0;
            norm_cnt_reg  <= '0;
            div_sel_reg   <= DV_U;
            any_hit_reg   <= 1'b0;
            best_u_reg    <= '0;
            best_v_reg    <= '0;
            best_dist_reg <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (accept) begin
                slot_reg     <= slot_reg[1] ? 2'd0 : slot_reg + 2'd1;
                last_reg     <= s_data.last_in_mesh;
                step_reg     <= '0;
                norm_cnt_reg <= '0;
                div_sel_reg  <= DV_U;
            end
            if (state_reg == S_MAC_WAIT && mac_stat.done) begin
                step_reg <= step_reg + STEP_W'(1);
            end
            if (state_reg == S_NORM) begin
                norm_cnt_reg <= norm_cnt_reg + 2'd1;
            end
            if (state_reg == S_DIV_WAIT && div_stat.done) begin
                unique case (div_sel_reg)
                    DV_U: begin
                        best_u_reg  <= div_quo[TEX_W-1:0];
                        div_sel_reg <= DV_V;
                    end
                    DV_V: begin
                        best_v_reg  <= div_quo[TEX_W-1:0];
                        div_sel_reg <= DV_T;
                    end
                    default: begin
                        best_dist_reg <= COORD_W'(0) - {1'b0, div_quo};
                        any_hit_reg   <= 1'b1;
                    end
                endcase
            end
            if (state_reg == S_SAT && sat) begin
                best_dist_reg <= DIST_SAT;
                any_hit_reg   <= 1'b1;
            end
            if (out_load) begin
                slot_reg      <= '0;
                any_hit_reg   <= 1'b0;
                best_u_reg    <= '0;
                best_v_reg    <= '0;
                best_dist_reg <= '0;
            end
        end
    end

    rmtp_mac u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (mac_cmd),
        .narrow  (mac_narrow),
        .wide    (mac_wide),
        .stat    (mac_stat),
        .acc     (mac_acc)
    );

    rmtp_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (div_cmd),
        .rem_init (div_rem),
        .low_bits (div_bits),
        .den      (det_reg[DEN_W-1:0]),
        .stat     (div_stat),
        .quo      (div_quo)
    );

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    a_no_hit_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.hit |-> m_data.hit_u == '0 && m_data.hit_v == '0
                                   && m_data.hit_distance == '0)
        else $error("result without a hit carries nonzero fields");

    a_dist_nonpos: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.hit_distance[COORD_W-1] || m_data.hit_distance == '0)
        else $error("hit distance is positive");

    a_units_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |-> !mac_stat.busy && !div_stat.busy)
        else $error("vertex accepted while an arithmetic unit is busy");

endmodule
